FILE: design/rcdd_pkg.sv
// ----------------------------------------------------------------------------
// rcdd_pkg
// Shared types, codes and arithmetic helpers for the differential drive mixer.
// ----------------------------------------------------------------------------
package rcdd_pkg;

    localparam logic [1:0] ACT_THR  = 2'd0;
    localparam logic [1:0] ACT_STR  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_UPD  = 2'd3;

    localparam logic [1:0] CST_NEVER   = 2'd0;
    localparam logic [1:0] CST_NORMAL  = 2'd1;
    localparam logic [1:0] CST_STR_TO  = 2'd2;
    localparam logic [1:0] CST_FAILSAFE = 2'd3;

    localparam logic [2:0] REG_THR_EXPO  = 3'd0;
    localparam logic [2:0] REG_STR_EXPO  = 3'd1;
    localparam logic [2:0] REG_ACCEL     = 3'd2;
    localparam logic [2:0] REG_BRAKE     = 3'd3;
    localparam logic [2:0] REG_STEER     = 3'd4;
    localparam logic [2:0] REG_TURN_GAIN = 3'd5;
    localparam logic [2:0] REG_MAX_TURN  = 3'd6;
    localparam logic [2:0] REG_TIMEOUT   = 3'd7;

    localparam logic [14:0] ONE_Q14     = 15'd16384;
    localparam logic [10:0] MID_US      = 11'd1500;
    localparam logic [14:0] PULSE_MIN   = 15'd850;
    localparam logic [14:0] PULSE_MAX   = 15'd2150;
    localparam logic [9:0]  DEADBAND_US = 10'd60;
    localparam logic [15:0] ZERO_THR    = 16'd492;
    localparam logic signed [15:0] SIDE_THR = 16'sd820;
    localparam logic [28:0] FWD_RANGE   = 29'd400;
    localparam logic [28:0] REV_RANGE   = 29'd144;
    localparam logic [28:0] RECIP_125   = 29'd67109;
    localparam logic [15:0] AGE_MAX     = 16'hFFFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PULSE_MUL,
        OP_PULSE_WR,
        OP_TICK,
        OP_STOP,
        OP_EXP0,
        OP_EXP1,
        OP_EXP2,
        OP_EXP3,
        OP_EXP4,
        OP_SLEW,
        OP_TURN_MUL,
        OP_TURN_CLAMP,
        OP_IN_MUL,
        OP_MIX,
        OP_PPM_M,
        OP_PPM_S,
        OP_PPM_END,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ch;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       tok;
        logic       stop_req;
    } sts_t;

    typedef struct packed {
        logic [14:0] thr_expo;
        logic [14:0] str_expo;
        logic [14:0] accel_step;
        logic [14:0] brake_step;
        logic [14:0] steer_step;
        logic [14:0] turn_gain;
        logic [14:0] max_turn;
        logic [15:0] timeout_ms;
    } cfg_t;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v < 0 ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [14:0] cap_w(input logic [14:0] w);
        return w > ONE_Q14 ? ONE_Q14 : w;
    endfunction

    function automatic logic signed [15:0] move_toward(input logic signed [15:0] cur,
                                                      input logic signed [15:0] tgt,
                                                      input logic [14:0] step);
        logic signed [17:0] c;
        logic signed [17:0] t;
        logic signed [17:0] up;
        logic signed [17:0] dn;
        c  = 18'(cur);
        t  = 18'(tgt);
        up = c + $signed({3'b000, step});
        dn = c - $signed({3'b000, step});
        if (cur < tgt) begin
            return up < t ? up[15:0] : tgt;
        end else if (cur > tgt) begin
            return dn > t ? dn[15:0] : tgt;
        end
        return cur;
    endfunction

    function automatic logic [10:0] ppm_from(input logic signed [15:0] cmd,
                                             input logic [57:0] prod);
        logic [10:0] k;
        k = prod[24:14];
        if (abs16(cmd) < ZERO_THR) begin
            return MID_US;
        end else if (cmd < 0) begin
            return MID_US - k;
        end
        return MID_US + k;
    endfunction

endpackage

FILE: design/rc_differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer
// RC throttle/steering pulses to two wheel PPM widths with expo, slew and mix.
// ----------------------------------------------------------------------------
// One result per input transfer. A drive update that goes ahead runs two cubic
// expo evaluations, the turn reduction and both PPM scalings one after the
// other through a single shared 29x29 multiplier. A new transfer is taken
// once the previous result is in the output register.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer import rcdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pulse_us[14:0], zero[15]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pulse_accepted[0], master_us[11:1], slave_us[22:12],
    // drive_mode[24:23], stop_flag[25], throttle_valid[26],
    // steering_valid[27], throttle_cmd[43:28], steering_cmd[59:44],
    // master_cmd[75:60], slave_cmd[91:76], zero[95:92]
    output logic [95:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr_expo   <= 15'd9830;
            cfg_reg.str_expo   <= 15'd8192;
            cfg_reg.accel_step <= 15'd246;
            cfg_reg.brake_step <= 15'd983;
            cfg_reg.steer_step <= 15'd328;
            cfg_reg.turn_gain  <= 15'd4915;
            cfg_reg.max_turn   <= 15'd12288;
            cfg_reg.timeout_ms <= 16'd300;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_THR_EXPO:  cfg_reg.thr_expo   <= pwdata[14:0];
                REG_STR_EXPO:  cfg_reg.str_expo   <= pwdata[14:0];
                REG_ACCEL:     cfg_reg.accel_step <= pwdata[14:0];
                REG_BRAKE:     cfg_reg.brake_step <= pwdata[14:0];
                REG_STEER:     cfg_reg.steer_step <= pwdata[14:0];
                REG_TURN_GAIN: cfg_reg.turn_gain  <= pwdata[14:0];
                REG_MAX_TURN:  cfg_reg.max_turn   <= pwdata[14:0];
                REG_TIMEOUT:   cfg_reg.timeout_ms <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THR_EXPO:  prdata = 32'(cfg_reg.thr_expo);
            REG_STR_EXPO:  prdata = 32'(cfg_reg.str_expo);
            REG_ACCEL:     prdata = 32'(cfg_reg.accel_step);
            REG_BRAKE:     prdata = 32'(cfg_reg.brake_step);
            REG_STEER:     prdata = 32'(cfg_reg.steer_step);
            REG_TURN_GAIN: prdata = 32'(cfg_reg.turn_gain);
            REG_MAX_TURN:  prdata = 32'(cfg_reg.max_turn);
            REG_TIMEOUT:   prdata = 32'(cfg_reg.timeout_ms);
        endcase
    end

    rcdd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    rcdd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg         (cfg_reg),
        .in_action   (s_axis_tuser),
        .in_pulse_us (s_axis_tdata[14:0]),
        .sts         (sts),
        .out_tdata   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_ppm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[11:1] >= 11'd1356) && (m_axis_tdata[11:1] <= 11'd1900)
                       && (m_axis_tdata[22:12] >= 11'd1356) && (m_axis_tdata[22:12] <= 11'd1900))
        else $error("ppm width out of range");
    a_normal_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[24:23] == CST_NORMAL) |-> m_axis_tdata[26] && m_axis_tdata[27])
        else $error("normal state without both channels valid");
    a_stop_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[25]) |-> !m_axis_tdata[26]
            && (m_axis_tdata[24:23] == CST_FAILSAFE || m_axis_tdata[24:23] == CST_NEVER))
        else $error("stop flagged outside a stop state");
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid && !m_axis_tready && $past(s_axis_tready)
          && $past(s_axis_tvalid) && !$past(m_axis_tvalid)))
        else $error("input taken twice without result");
`endif

endmodule

FILE: design/rcdd_ctrl.sv
// ----------------------------------------------------------------------------
// rcdd_ctrl
// Sequencer: steps the datapath through pulse, tick and drive update work.
// ----------------------------------------------------------------------------
module rcdd_ctrl import rcdd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_PL_MUL, ST_PL_WR, ST_TICK, ST_STOP,
        ST_EXP0, ST_EXP1, ST_EXP2, ST_EXP3, ST_EXP4, ST_CHK, ST_SLEW,
        ST_TURN_MUL, ST_TURN_CLAMP, ST_IN_MUL, ST_MIX,
        ST_PPM_M, ST_PPM_S, ST_PPM_END, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ch_reg, ch_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free      = !mvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        cmd.op      = OP_NONE;
        cmd.ch      = ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                ch_next = 1'b0;
                unique case (sts.action) inside
                    ACT_THR, ACT_STR: state_next = ST_PL_MUL;
                    ACT_TICK:         state_next = ST_TICK;
                    ACT_UPD:          state_next = sts.tok ? ST_EXP0 : ST_STOP;
                endcase
            end
            ST_PL_MUL: begin
                cmd.op     = OP_PULSE_MUL;
                state_next = ST_PL_WR;
            end
            ST_PL_WR: begin
                cmd.op     = OP_PULSE_WR;
                state_next = ST_FIN;
            end
            ST_TICK: begin
                cmd.op     = OP_TICK;
                state_next = ST_FIN;
            end
            ST_STOP: begin
                cmd.op     = OP_STOP;
                state_next = ST_FIN;
            end
            ST_EXP0: begin
                cmd.op     = OP_EXP0;
                state_next = ST_EXP1;
            end
            ST_EXP1: begin
                cmd.op     = OP_EXP1;
                state_next = ST_EXP2;
            end
            ST_EXP2: begin
                cmd.op     = OP_EXP2;
                state_next = ST_EXP3;
            end
            ST_EXP3: begin
                cmd.op     = OP_EXP3;
                state_next = ST_EXP4;
            end
            ST_EXP4: begin
                cmd.op = OP_EXP4;
                if (ch_reg) begin
                    state_next = ST_CHK;
                end else begin
                    ch_next    = 1'b1;
                    state_next = ST_EXP0;
                end
            end
            ST_CHK: begin
                state_next = sts.stop_req ? ST_STOP : ST_SLEW;
            end
            ST_SLEW: begin
                cmd.op     = OP_SLEW;
                state_next = ST_TURN_MUL;
            end
            ST_TURN_MUL: begin
                cmd.op     = OP_TURN_MUL;
                state_next = ST_TURN_CLAMP;
            end
            ST_TURN_CLAMP: begin
                cmd.op     = OP_TURN_CLAMP;
                state_next = ST_IN_MUL;
            end
            ST_IN_MUL: begin
                cmd.op     = OP_IN_MUL;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.op     = OP_MIX;
                state_next = ST_PPM_M;
            end
            ST_PPM_M: begin
                cmd.op     = OP_PPM_M;
                state_next = ST_PPM_S;
            end
            ST_PPM_S: begin
                cmd.op     = OP_PPM_S;
                state_next = ST_PPM_END;
            end
            ST_PPM_END: begin
                cmd.op     = OP_PPM_END;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.op      = OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ch_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

FILE: design/rcdd_dp.sv
// ----------------------------------------------------------------------------
// rcdd_dp
// Datapath: channel state, shared 29x29 multiplier, expo, slew, mixing, PPM.
// ----------------------------------------------------------------------------
module rcdd_dp import rcdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  cfg_t        cfg,
    input  logic [1:0]  in_action,
    input  logic [14:0] in_pulse_us,
    output sts_t        sts,
    output logic [95:0] out_tdata
);

    logic [1:0]  action_reg;
    logic [14:0] pw_reg;
    logic        acc_reg;
    logic signed [15:0] tnorm_reg, snorm_reg;
    logic [15:0] tage_reg, sage_reg;
    logic        tseen_reg, sseen_reg;
    logic signed [15:0] tlev_reg, slev_reg;
    logic signed [15:0] tshp_reg, sshp_reg;
    logic [28:0] a2_reg, ea_reg, b_reg;
    logic [57:0] prod_reg;
    logic [14:0] turn_reg;
    logic signed [15:0] mix0_reg, mix1_reg;
    logic [10:0] ppm0_reg, ppm1_reg;
    logic [95:0] tdata_reg;

    logic        tok, sok;
    logic signed [15:0] dev;
    logic [15:0] dev_abs;
    logic [9:0]  pa;
    logic        in_range;
    logic [16:0] nsum;
    logic [14:0] nmag;
    logic signed [15:0] nval;
    logic signed [15:0] xsel;
    logic [15:0] xa;
    logic [14:0] ew;
    logic [57:0] esum;
    logic signed [15:0] eres;
    logic [28:0] mul_a, mul_b;
    logic [15:0] ta, tla;
    logic        braking;
    logic [14:0] tq, mt;
    logic signed [15:0] inner;
    logic signed [15:0] snorm_out;
    logic [1:0]  cstate;

    assign tok = tseen_reg && (tage_reg <= cfg.timeout_ms);
    assign sok = sseen_reg && (sage_reg <= cfg.timeout_ms);

    assign dev      = $signed({1'b0, pw_reg}) - $signed({5'b0, MID_US});
    assign dev_abs  = abs16(dev);
    assign pa       = dev_abs[9:0];
    assign in_range = (pw_reg >= PULSE_MIN) && (pw_reg <= PULSE_MAX);
    assign nsum     = 17'({pa, 5'b0}) + 17'(prod_reg[38:23]);
    assign nmag     = (pa < DEADBAND_US) ? 15'd0 :
                      (nsum > 17'(ONE_Q14)) ? ONE_Q14 : nsum[14:0];
    assign nval     = (dev < 0) ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});

    assign xsel = cmd.ch ? (sok ? snorm_reg : 16'sd0) : tnorm_reg;
    assign xa   = abs16(xsel);
    assign ew   = cap_w(cmd.ch ? cfg.str_expo : cfg.thr_expo);
    assign esum = prod_reg + {1'b0, b_reg, 28'b0};
    assign eres = (xsel < 0) ? -$signed(esum[57:42]) : $signed(esum[57:42]);

    assign ta      = abs16(tshp_reg);
    assign tla     = abs16(tlev_reg);
    assign braking = (ta < tla) || ((ta < ZERO_THR) && (tla >= ZERO_THR));

    assign tq    = prod_reg[28:14];
    assign mt    = cap_w(cfg.max_turn);
    assign inner = (tlev_reg < 0) ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

    assign sts.action   = action_reg;
    assign sts.tok      = tok;
    assign sts.stop_req = (abs16(tshp_reg) < ZERO_THR) && (abs16(sshp_reg) < ZERO_THR);

    assign snorm_out = sok ? snorm_reg : 16'sd0;
    assign cstate    = !tok ? (tseen_reg ? CST_FAILSAFE : CST_NEVER) :
                       (!sok ? CST_STR_TO : CST_NORMAL);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_PULSE_MUL: begin
                mul_a = 29'({pa, 6'b0}) + 29'({pa, 5'b0});
                mul_b = RECIP_125;
            end
            OP_EXP0: begin
                mul_a = 29'(xa);
                mul_b = 29'(xa);
            end
            OP_EXP1: begin
                mul_a = 29'(xa);
                mul_b = 29'(ew);
            end
            OP_EXP2: begin
                mul_a = 29'(xa);
                mul_b = 29'(ONE_Q14 - ew);
            end
            OP_EXP3: begin
                mul_a = a2_reg;
                mul_b = ea_reg;
            end
            OP_TURN_MUL: begin
                mul_a = 29'(abs16(slev_reg));
                mul_b = 29'(cfg.turn_gain);
            end
            OP_IN_MUL: begin
                mul_a = 29'(tla);
                mul_b = 29'(ONE_Q14 - turn_reg);
            end
            OP_PPM_M: begin
                mul_a = 29'(abs16(mix0_reg));
                mul_b = (mix0_reg < 0) ? REV_RANGE : FWD_RANGE;
            end
            OP_PPM_S: begin
                mul_a = 29'(abs16(mix1_reg));
                mul_b = (mix1_reg < 0) ? REV_RANGE : FWD_RANGE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 58'(mul_a) * 58'(mul_b);
        case (cmd.op)
            OP_LOAD: begin
                action_reg <= in_action;
                pw_reg     <= in_pulse_us;
                acc_reg    <= 1'b0;
            end
            OP_EXP1: a2_reg <= prod_reg[28:0];
            OP_EXP2: ea_reg <= prod_reg[28:0];
            OP_EXP3: b_reg  <= prod_reg[28:0];
            OP_PULSE_WR: acc_reg <= in_range;
            OP_TURN_CLAMP: turn_reg <= (tq > mt) ? mt : tq;
            OP_OUT: begin
                tdata_reg <= {4'b0, mix1_reg, mix0_reg, snorm_out, tnorm_reg,
                              sok, tok, !tok, cstate, ppm1_reg, ppm0_reg, acc_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tnorm_reg <= '0;
            snorm_reg <= '0;
            tage_reg  <= '0;
            sage_reg  <= '0;
            tseen_reg <= 1'b0;
            sseen_reg <= 1'b0;
            tlev_reg  <= '0;
            slev_reg  <= '0;
            tshp_reg  <= '0;
            sshp_reg  <= '0;
            mix0_reg  <= '0;
            mix1_reg  <= '0;
            ppm0_reg  <= MID_US;
            ppm1_reg  <= MID_US;
        end else begin
            case (cmd.op)
                OP_PULSE_WR: begin
                    if (in_range) begin
                        if (action_reg == ACT_THR) begin
                            tnorm_reg <= -nval;
                            tage_reg  <= '0;
                            tseen_reg <= 1'b1;
                        end else begin
                            snorm_reg <= nval;
                            sage_reg  <= '0;
                            sseen_reg <= 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if (tage_reg != AGE_MAX) tage_reg <= tage_reg + 16'd1;
                    if (sage_reg != AGE_MAX) sage_reg <= sage_reg + 16'd1;
                end
                OP_STOP: begin
                    tlev_reg <= '0;
                    slev_reg <= '0;
                    mix0_reg <= '0;
                    mix1_reg <= '0;
                    ppm0_reg <= MID_US;
                    ppm1_reg <= MID_US;
                end
                OP_EXP4: begin
                    if (cmd.ch) sshp_reg <= eres;
                    else        tshp_reg <= eres;
                end
                OP_SLEW: begin
                    tlev_reg <= move_toward(tlev_reg, tshp_reg,
                                            braking ? cfg.brake_step : cfg.accel_step);
                    slev_reg <= move_toward(slev_reg, sshp_reg, cfg.steer_step);
                end
                OP_MIX: begin
                    if (slev_reg >= SIDE_THR) begin
                        mix0_reg <= tlev_reg;
                        mix1_reg <= inner;
                    end else if (slev_reg <= -SIDE_THR) begin
                        mix0_reg <= inner;
                        mix1_reg <= tlev_reg;
                    end else begin
                        mix0_reg <= tlev_reg;
                        mix1_reg <= tlev_reg;
                    end
                end
                OP_PPM_S:   ppm0_reg <= ppm_from(mix0_reg, prod_reg);
                OP_PPM_END: ppm1_reg <= ppm_from(mix1_reg, prod_reg);
                default: ;
            endcase
        end
    end

    assign out_tdata = tdata_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the differential drive mixer. A directed opening
// and weighted random pulse, tick and update streams run under several
// register settings and handshake pressures. A cycle-free predictor works out
// every status and wheel field, and each result transfer is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb import rcdd_pkg::*; ();

    typedef struct {
        logic [1:0]  action;
        logic [14:0] pulse;
    } pulse_item_t;

    typedef struct packed {
        logic signed [15:0] slave_cmd;
        logic signed [15:0] master_cmd;
        logic signed [15:0] str_norm;
        logic signed [15:0] thr_norm;
        logic               str_ok;
        logic               thr_ok;
        logic               stop;
        logic [1:0]         state;
        logic [10:0]        slave_ppm;
        logic [10:0]        master_ppm;
        logic               accepted;
    } drive_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rc_differential_drive_mixer DUT (.*);

    pulse_item_t pend_q[$];
    drive_res_t  drive_exp_q[$];
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        tx_taken;
    int          hold_req;
    int          hold_seen;
    int          hold_cnt;
    int          mismatches;
    int          results_seen;
    int          updates_sent;

    // predictor state
    int unsigned cfg_q[8];
    int          thr_w;
    int          str_w;
    int unsigned thr_age;
    int unsigned str_age;
    bit          thr_seen;
    bit          str_seen;
    int          thr_lvl;
    int          str_lvl;
    int          mix_m;
    int          mix_s;
    int          ppm_m;
    int          ppm_s;

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int capped(int unsigned w);
        return w > 16384 ? 16384 : int'(w);
    endfunction

    function automatic int stick_norm(int width, bit negate);
        int c;
        int x;
        c = width - 1500;
        if (iabs(c) < 60) return 0;
        x = (c * 16384) / 500;
        if (x > 16384) x = 16384;
        if (x < -16384) x = -16384;
        return negate ? -x : x;
    endfunction

    function automatic int shape_expo(int x, int unsigned w);
        longint e;
        longint xx;
        longint num;
        e   = capped(w);
        xx  = x;
        num = (64'sd16384 - e) * xx * (64'sd1 <<< 28) + e * xx * xx * xx;
        return int'(num / (64'sd1 <<< 42));
    endfunction

    function automatic int ramp_to(int cur, int tgt, int step);
        if (cur < tgt) return (cur + step < tgt) ? cur + step : tgt;
        if (cur > tgt) return (cur - step > tgt) ? cur - step : tgt;
        return cur;
    endfunction

    function automatic int ppm_width(int cmd);
        if (iabs(cmd) < 492) return 1500;
        if (cmd > 0) return 1500 + (cmd * 400) / 16384;
        return 1500 + (cmd * 144) / 16384;
    endfunction

    function automatic void stop_drive();
        thr_lvl = 0;
        str_lvl = 0;
        mix_m   = 0;
        mix_s   = 0;
        ppm_m   = 1500;
        ppm_s   = 1500;
    endfunction

    function automatic void drive_step(bit t_ok, bit s_ok);
        int  thr;
        int  str;
        int  turn;
        int  inner;
        bit  braking;
        if (!t_ok) begin
            stop_drive();
            return;
        end
        thr = shape_expo(stick_norm(thr_w, 1'b1), cfg_q[REG_THR_EXPO]);
        str = s_ok ? shape_expo(stick_norm(str_w, 1'b0), cfg_q[REG_STR_EXPO]) : 0;
        if (iabs(thr) < 492 && iabs(str) < 492) begin
            stop_drive();
            return;
        end
        braking = iabs(thr) < iabs(thr_lvl) || (iabs(thr) < 492 && iabs(thr_lvl) >= 492);
        thr_lvl = ramp_to(thr_lvl, thr,
                          int'(braking ? cfg_q[REG_BRAKE] : cfg_q[REG_ACCEL]));
        str_lvl = ramp_to(str_lvl, str, int'(cfg_q[REG_STEER]));
        turn = (iabs(str_lvl) * int'(cfg_q[REG_TURN_GAIN])) / 16384;
        if (turn > capped(cfg_q[REG_MAX_TURN])) turn = capped(cfg_q[REG_MAX_TURN]);
        inner = (thr_lvl * (16384 - turn)) / 16384;
        mix_m = thr_lvl;
        mix_s = thr_lvl;
        if (str_lvl >= 820) mix_s = inner;
        else if (str_lvl <= -820) mix_m = inner;
        ppm_m = ppm_width(mix_m);
        ppm_s = ppm_width(mix_s);
    endfunction

    function automatic drive_res_t predict_drive(logic [1:0] action, int unsigned pw);
        drive_res_t r;
        bit         t_ok;
        bit         s_ok;
        r = '0;
        if (action == ACT_THR || action == ACT_STR) begin
            if (pw >= 850 && pw <= 2150) begin
                r.accepted = 1'b1;
                if (action == ACT_THR) begin
                    thr_w = int'(pw); thr_age = 0; thr_seen = 1'b1;
                end else begin
                    str_w = int'(pw); str_age = 0; str_seen = 1'b1;
                end
            end
        end else if (action == ACT_TICK) begin
            if (thr_age < 65535) thr_age++;
            if (str_age < 65535) str_age++;
        end
        t_ok = thr_seen && thr_age <= cfg_q[REG_TIMEOUT];
        s_ok = str_seen && str_age <= cfg_q[REG_TIMEOUT];
        if (action == ACT_UPD) drive_step(t_ok, s_ok);
        if (!t_ok) r.state = thr_seen ? CST_FAILSAFE : CST_NEVER;
        else if (!s_ok) r.state = CST_STR_TO;
        else r.state = CST_NORMAL;
        r.stop       = !t_ok;
        r.thr_ok     = t_ok;
        r.str_ok     = s_ok;
        r.thr_norm   = 16'(stick_norm(thr_w, 1'b1));
        r.str_norm   = s_ok ? 16'(stick_norm(str_w, 1'b0)) : 16'sd0;
        r.master_cmd = 16'(mix_m);
        r.slave_cmd  = 16'(mix_s);
        r.master_ppm = 11'(ppm_m);
        r.slave_ppm  = 11'(ppm_s);
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("timeout with %0d results outstanding", drive_exp_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // sender: offer the next pending transfer at the falling edge
    always @(negedge aclk) begin
        pulse_item_t it;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || tx_taken) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                it = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, it.pulse};
                s_axis_tuser  <= it.action;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        tx_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            drive_exp_q.push_back(predict_drive(s_axis_tuser, s_axis_tdata[14:0]));
            if (s_axis_tuser == ACT_UPD) updates_sent++;
        end
    end

    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_cnt  <= 400;
            hold_seen <= hold_req;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= aresetn && hold_cnt == 0 && $urandom_range(0, 99) >= rx_idle_pct;
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        drive_res_t exp_r;
        drive_res_t got;
        int         ev[11];
        int         gv[11];
        string      nm[11];
        bit         bad;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[91:0];
            results_seen++;
            if (drive_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                exp_r = drive_exp_q.pop_front();
                nm = '{"pulse_accepted", "master_us", "slave_us", "drive_mode",
                       "stop_flag", "throttle_valid", "steering_valid", "throttle_cmd",
                       "steering_cmd", "master_cmd", "slave_cmd"};
                ev = '{exp_r.accepted, exp_r.master_ppm, exp_r.slave_ppm, exp_r.state,
                       exp_r.stop, exp_r.thr_ok, exp_r.str_ok, exp_r.thr_norm,
                       exp_r.str_norm, exp_r.master_cmd, exp_r.slave_cmd};
                gv = '{got.accepted, got.master_ppm, got.slave_ppm, got.state,
                       got.stop, got.thr_ok, got.str_ok, got.thr_norm,
                       got.str_norm, got.master_cmd, got.slave_cmd};
                bad = 1'b0;
                for (int i = 0; i < 11; i++) begin
                    if (ev[i] != gv[i]) begin
                        if (!bad) mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d %s: expected %0d, got %0d",
                                     results_seen, nm[i], ev[i], gv[i]);
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_q[idx] = val & (idx == REG_TIMEOUT ? 32'hFFFF : 32'h7FFF);
    endtask

    task automatic add_item(logic [1:0] action, int unsigned pw);
        pulse_item_t it;
        it.action = action;
        it.pulse  = 15'(pw);
        pend_q.push_back(it);
    endtask

    task automatic add_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 9) == 0) add_item(r < 22 ? ACT_THR : ACT_STR,
                                                         $urandom_range(0, 25000));
                else add_item(r < 22 ? ACT_THR : ACT_STR, $urandom_range(850, 2150));
            end else if (r < 70) begin
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 60) : 1)
                    add_item(ACT_TICK, $urandom_range(0, 32767));
            end else begin
                add_item(ACT_UPD, $urandom_range(0, 32767));
            end
        end
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_axis_tvalid || drive_exp_q.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    initial begin
        int unsigned cfg_init[8];
        cfg_init = '{9830, 8192, 246, 983, 328, 4915, 12288, 300};
        cfg_q = cfg_init;
        thr_w = 1500; str_w = 1500; thr_age = 0; str_age = 0;
        thr_seen = 0; str_seen = 0;
        stop_drive();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = ACT_THR;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        tx_taken = 1'b0;
        hold_req = 0; hold_seen = 0; hold_cnt = 0;
        mismatches = 0; results_seen = 0; updates_sent = 0;
        tx_idle_pct = 6; rx_idle_pct = 82;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // opening: extremes, rejects, each action and the stop paths
        add_item(ACT_UPD, 0);
        add_item(ACT_TICK, 25000);
        add_item(ACT_THR, 849);
        add_item(ACT_THR, 2151);
        add_item(ACT_THR, 0);
        add_item(ACT_THR, 25000);
        add_item(ACT_THR, 850);
        add_item(ACT_UPD, 32767);
        add_item(ACT_UPD, 0);
        add_item(ACT_STR, 2150);
        add_item(ACT_UPD, 0);
        add_item(ACT_STR, 850);
        add_item(ACT_UPD, 0);
        add_item(ACT_THR, 2150);
        add_item(ACT_UPD, 0);
        add_item(ACT_UPD, 0);
        add_item(ACT_THR, 1500);
        add_item(ACT_STR, 1500);
        add_item(ACT_UPD, 0);
        add_item(ACT_THR, 1559);
        add_item(ACT_STR, 1441);
        add_item(ACT_UPD, 0);
        add_item(ACT_THR, 1000);
        add_item(ACT_UPD, 0);
        add_random(150);
        drain();

        reg_write(REG_THR_EXPO, 0);
        reg_write(REG_STR_EXPO, 0);
        reg_write(REG_ACCEL, 16384);
        reg_write(REG_BRAKE, 16384);
        reg_write(REG_STEER, 16384);
        reg_write(REG_TURN_GAIN, 16384);
        reg_write(REG_MAX_TURN, 16384);
        reg_write(REG_TIMEOUT, 0);
        tx_idle_pct = 82; rx_idle_pct = 6;
        add_random(130);
        drain();

        reg_write(REG_THR_EXPO, 32767);
        reg_write(REG_STR_EXPO, 32767);
        reg_write(REG_ACCEL, 1);
        reg_write(REG_BRAKE, 32767);
        reg_write(REG_STEER, 32767);
        reg_write(REG_TURN_GAIN, 32767);
        reg_write(REG_MAX_TURN, 32767);
        reg_write(REG_TIMEOUT, 65535);
        tx_idle_pct = 0; rx_idle_pct = 0;
        add_random(130);
        drain();

        for (int k = 0; k < 7; k++) reg_write(3'(k), $urandom_range(0, 16384));
        reg_write(REG_TIMEOUT, $urandom_range(5, 60));
        hold_req++;
        add_random(160);
        drain();

        // let both channels time out, then bring the throttle back
        reg_write(REG_TIMEOUT, 40);
        add_item(ACT_THR, 1900);
        add_item(ACT_STR, 1200);
        add_item(ACT_UPD, 0);
        repeat (45) add_item(ACT_TICK, 0);
        add_item(ACT_UPD, 0);
        add_item(ACT_THR, 1100);
        add_item(ACT_UPD, 0);
        drain();

        $display("covered %0d results, %0d drive updates, five register settings",
                 results_seen, updates_sent);
        $display("mismatching results: %0d", mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
